>>> src/dsoi_pkg.sv
// ============================================================================
// dsoi_pkg: shared types and constants for the decimating sparse offset index
// Table geometry, command codes, entry layout, sequencer states and the
// status bundle of the remainder unit.
// ============================================================================
`default_nettype none

package dsoi_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int HALF_DEPTH  = TABLE_DEPTH / 2;
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 16;
    localparam int ENTRY_W     = 2 * DATA_W;

    localparam logic [DATA_W-1:0] DEFAULT_INTERVAL = 32'd5;
    localparam logic [DATA_W-1:0] INTERVAL_CAP     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INTERVAL_SAT     = 32'h4000_0000;

    typedef enum logic
    {
        CMD_ADD  = 1'b0,
        CMD_FIND = 1'b1
    } dsoi_cmd_t;

    typedef struct packed
    {
        logic [DATA_W-1:0] index;
        logic [DATA_W-1:0] offset;
    } dsoi_entry_t;

    typedef struct packed
    {
        logic busy;
        logic done;
        logic zero;
    } dsoi_mod_status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_MOD,
        S_COMPACT,
        S_CMP_LAST,
        S_APPEND,
        S_SCAN,
        S_DONE
    } dsoi_state_t;

endpackage

`default_nettype wire

>>> src/decimating_sparse_offset_index.sv
// ============================================================================
// decimating_sparse_offset_index: sparse record-number to byte-offset index
// Records (index, offset) pairs at a decimating interval and answers
// nearest-not-above lookups (entry 0 for keys below it) from a synchronous RAM.
// ============================================================================
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+-----------
//  input    | in_valid, in_stall, command/index/offset | in (stall out)
//  result   | out_valid, out_stall, ok/found_index/found_offset | out (stall in)
//  config   | cfg_we, cfg_data                      | in
//
//  Add: the command is accepted, then waits in S_MOD on the bit-serial
//    remainder unit (one step per dividend bit, then its done flag),
//    appends when the index is recorded, then presents its result; a full
//    table is first compacted through S_COMPACT and S_CMP_LAST.
//  Find: entries are scanned in order through the RAM read port, up to
//    the number of used entries, then the result is presented.
//  Reset clears the count and largest index and loads the default interval;
//    the RAM needs no clearing pass since only written entries are ever read.
//  A finished result waits in the output register; a new item is taken
//    while it stalls, and the next result holds until the register drains.
// ============================================================================
`default_nettype none

module decimating_sparse_offset_index import dsoi_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_we,
    input  wire logic [CFG_W-1:0]  cfg_data,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              command,
    input  wire logic [DATA_W-1:0] index,
    input  wire logic [DATA_W-1:0] offset,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   ok,
    output logic      [DATA_W-1:0] found_index,
    output logic      [DATA_W-1:0] found_offset
);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    dsoi_state_t       state_reg,    state_next;
    dsoi_cmd_t         cmd_reg,      cmd_next;
    logic [DATA_W-1:0] idx_reg,      idx_next;
    logic [DATA_W-1:0] off_reg,      off_next;
    logic [COUNT_W-1:0] used_reg,    used_next;
    logic [DATA_W-1:0] largest_reg,  largest_next;
    logic [DATA_W-1:0] interval_reg, interval_next;
    logic [ADDR_W-1:0] cnt_reg,      cnt_next;
    logic [ADDR_W-1:0] scan_k_reg,   scan_k_next;
    dsoi_entry_t       prev_reg,     prev_next;
    logic              res_ok_reg,   res_ok_next;
    dsoi_entry_t       res_reg,      res_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg,   out_ok_next;
    dsoi_entry_t       out_reg,      out_next;

    // RAM ports
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    dsoi_entry_t       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_raw;
    dsoi_entry_t       rd_entry;

    // remainder unit
    logic              mod_start;
    dsoi_mod_status_t  mod_status;

    logic              in_xfer;
    logic              out_free;
    logic              recordable;
    logic [COUNT_W-1:0] last_k;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_entry = dsoi_entry_t'(rd_raw);
    assign last_k   = used_reg - 1'b1;
    assign mod_start = in_xfer && (command == CMD_ADD);

    // record only multiples of the interval that extend the table upward
    assign recordable = mod_status.zero &&
                        ((used_reg == '0) || (idx_reg > largest_reg));

    dsoi_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    dsoi_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (index),
        .divisor  (interval_reg),
        .status   (mod_status)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        off_next      = off_reg;
        used_next     = used_reg;
        largest_next  = largest_reg;
        interval_next = interval_reg;
        cnt_next      = cnt_reg;
        scan_k_next   = scan_k_reg;
        prev_next     = prev_reg;
        res_ok_next   = res_ok_reg;
        res_next      = res_reg;
        out_ok_next   = out_ok_reg;
        out_next      = out_reg;

        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = '0;

        // drain the output register
        out_valid_next = out_valid_reg && out_stall;

        // reload the interval on a register write; zero loads the default
        if (cfg_we)
        begin
            interval_next = (cfg_data == '0) ? DEFAULT_INTERVAL : DATA_W'(cfg_data);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next    = dsoi_cmd_t'(command);
                    idx_next    = index;
                    off_next    = offset;
                    res_ok_next = 1'b1;
                    res_next    = '0;
                    if (command == CMD_ADD)
                    begin
                        state_next = S_MOD;
                    end
                    else if (used_reg == '0)
                    begin
                        // find on an empty table fails
                        res_ok_next = 1'b0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = '0;
                        scan_k_next = '0;
                        state_next  = S_SCAN;
                    end
                end
            end

            S_MOD:
            begin
                if (mod_status.done)
                begin
                    if (!recordable)
                    begin
                        state_next = S_DONE;
                    end
                    else if (used_reg == COUNT_W'(TABLE_DEPTH))
                    begin
                        cnt_next   = '0;
                        state_next = S_COMPACT;
                    end
                    else
                    begin
                        state_next = S_APPEND;
                    end
                end
            end

            S_COMPACT:
            begin
                // read entry 2k, write the entry read last cycle to k-1
                rd_en   = 1'b1;
                rd_addr = ADDR_W'({cnt_reg, 1'b0});
                if (cnt_reg != '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = cnt_reg - 1'b1;
                    wr_data = rd_entry;
                end
                if (cnt_reg == ADDR_W'(HALF_DEPTH - 1))
                begin
                    state_next = S_CMP_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_CMP_LAST:
            begin
                wr_en     = 1'b1;
                wr_addr   = cnt_reg;
                wr_data   = rd_entry;
                used_next = COUNT_W'(HALF_DEPTH);
                // double the interval, saturating at the cap
                interval_next = (interval_reg >= INTERVAL_SAT) ? INTERVAL_CAP
                                                               : {interval_reg[DATA_W-2:0], 1'b0};
                state_next = S_APPEND;
            end

            S_APPEND:
            begin
                wr_en          = 1'b1;
                wr_addr        = used_reg[ADDR_W-1:0];
                wr_data.index  = idx_reg;
                wr_data.offset = off_reg;
                used_next      = used_reg + 1'b1;
                largest_next   = idx_reg;
                state_next     = S_DONE;
            end

            S_SCAN:
            begin
                // rd_entry holds entry scan_k
                if (idx_reg < rd_entry.index)
                begin
                    res_next   = (scan_k_reg == '0) ? rd_entry : prev_reg;
                    state_next = S_DONE;
                end
                else if ({1'b0, scan_k_reg} == last_k)
                begin
                    res_next   = rd_entry;
                    state_next = S_DONE;
                end
                else
                begin
                    prev_next   = rd_entry;
                    rd_en       = 1'b1;
                    rd_addr     = scan_k_reg + 1'b1;
                    scan_k_next = scan_k_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            largest_reg   <= '0;
            interval_reg  <= DEFAULT_INTERVAL;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            scan_k_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            largest_reg   <= largest_next;
            interval_reg  <= interval_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            scan_k_reg    <= scan_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        off_reg    <= off_next;
        prev_reg   <= prev_next;
        res_ok_reg <= res_ok_next;
        res_reg    <= res_next;
        out_ok_reg <= out_ok_next;
        out_reg    <= out_next;
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign ok           = out_ok_reg;
    assign found_index  = out_reg.index;
    assign found_offset = out_reg.offset;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= COUNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_interval_range: assert property (@(posedge clk) disable iff (!rst_n)
        (interval_reg != '0) && (interval_reg <= INTERVAL_CAP))
        else $error("interval out of range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result presented outside the done state");

    a_largest_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (largest_reg >= $past(largest_reg)))
        else $error("largest index decreased");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (used_reg != '0))
        else $error("scan on an empty table");

endmodule

`default_nettype wire

>>> src/dsoi_ram.sv
// ============================================================================
// dsoi_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and appears in the cycle after the read.
// ============================================================================
`default_nettype none

module dsoi_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> src/dsoi_mod.sv
// ============================================================================
// dsoi_mod: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; reports whether the
// remainder is zero.
// ============================================================================
`default_nettype none

module dsoi_mod import dsoi_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output dsoi_mod_status_t       status
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [DATA_W-1:0] quo_reg,  quo_next;
    logic [DATA_W-1:0] rem_reg,  rem_next;
    logic [DATA_W-1:0] div_reg,  div_next;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // subtract when the shifted remainder reaches the divisor
            rem_next = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

`default_nettype wire
